// File: rtl/assert_macros.svh
// assertion helpers for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CHK_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("check failed");

`define CHK_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("check failed");

`endif

// File: rtl/mtme_pkg.sv
package mtme_pkg;

  localparam int InWidth  = 104;
  localparam int OutWidth = 104;

  typedef enum logic [1:0] {
    CMD_SEND   = 2'd0,
    CMD_POST   = 2'd1,
    CMD_CANCEL = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_MATCHED    = 3'd0,
    ST_POSTED     = 3'd1,
    ST_UNEXPECTED = 3'd2,
    ST_FORWARD    = 3'd3,
    ST_FULL       = 3'd4,
    ST_CANCELLED  = 3'd5,
    ST_NOT_FOUND  = 3'd6
  } status_t;

  localparam logic REG_ENABLE = 1'b0;
  localparam logic REG_MPW    = 1'b1;

  typedef struct packed {
    logic [15:0] comm;
    logic [15:0] tag;
    logic        any_tag;
    logic [11:0] src;
    logic        any_src;
    logic [15:0] handle;
    logic [31:0] cap;
  } posted_t;

  typedef struct packed {
    logic [15:0] comm;
    logic [15:0] tag;
    logic [11:0] src;
    logic        sync;
    logic [15:0] handle;
    logic [31:0] len;
  } unexp_t;

endpackage

// File: rtl/message_tag_matching_engine.sv
// Message tag matching engine. Each input beat is one command: a send arrival,
// a receive post or a receive cancel; each gives exactly one result beat. The
// posted and unexpected queues are memories kept in arrival order, searched by
// one shared compare unit one entry at a time (read, then compare), oldest
// first. A hit is removed by a compaction sweep that moves every later entry
// down one place, again with a read and then a write for each entry. On a miss
// a send or post is appended to its queue unless it is full or forwarded; a
// disabled engine or an unknown command skips the search. The result waits for
// m_axis_tready, and s_axis_tready is low until the result has been taken. No
// clearing pass is needed after reset.
module message_tag_matching_engine
  import mtme_pkg::*;
#(
  parameter int POSTED_DEPTH     = 32,
  parameter int UNEXPECTED_DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // command, comm_id, tag, any_tag, source_rank, any_src, length, handle, is_sync
  input  logic [InWidth-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // status, recv_handle, msg_handle, matched_source, matched_tag,
  // delivered_length, truncated, sync_release
  output logic [OutWidth-1:0] m_axis_tdata,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic                cfg_data
);

  localparam int PW = $clog2(POSTED_DEPTH);
  localparam int UW = $clog2(UNEXPECTED_DEPTH);
  localparam int CW = (PW > UW ? PW : UW) + 1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_CHECK = 6'b000100,
    S_SHIFT = 6'b001000,
    S_WRITE = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state;
  logic enable, mpw;
  logic [PW:0] posted_count;
  logic [UW:0] unexp_count;
  posted_t posted_mem [POSTED_DEPTH];
  unexp_t  unexp_mem [UNEXPECTED_DEPTH];
  posted_t p_rd;
  unexp_t  u_rd;

  logic [1:0]  cmd;
  logic [15:0] comm, tag, hnd;
  logic        anyt, anys, sync;
  logic [11:0] src;
  logic [31:0] len;

  logic [CW-1:0] idx;
  logic          use_unexp;
  logic [OutWidth-1:0] result;
  logic [CW-1:0] limit;
  logic hit_send, hit_post, hit_cancel, hit;
  logic [31:0] other_len;
  logic trunc;

  assign limit = use_unexp ? CW'(unexp_count) : CW'(posted_count);

  always_comb begin
    hit_send = (p_rd.comm == comm) && (p_rd.any_tag || p_rd.tag == tag) &&
               (p_rd.any_src || p_rd.src == src);
    hit_post = (u_rd.comm == comm) && (anyt || u_rd.tag == tag) &&
               (anys || u_rd.src == src);
    hit_cancel = (p_rd.handle == hnd);
    if (cmd == CMD_SEND) hit = hit_send;
    else if (cmd == CMD_POST) hit = hit_post;
    else hit = hit_cancel;
    other_len = use_unexp ? u_rd.len : p_rd.cap;
    trunc = use_unexp ? (u_rd.len > len) : (len > p_rd.cap);
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = result;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0;
      mpw <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == REG_ENABLE) enable <= cfg_data;
      else mpw <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    p_rd <= posted_mem[idx[PW-1:0]];
    u_rd <= unexp_mem[idx[UW-1:0]];
  end

  function automatic logic [OutWidth-1:0] pack_out(
    status_t st, logic [15:0] rh, logic [15:0] mh, logic [11:0] ms,
    logic [15:0] mt, logic [31:0] dl, logic tr, logic sr);
    return OutWidth'({sr, tr, dl, mt, ms, mh, rh, st});
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      posted_count <= '0;
      unexp_count <= '0;
      idx <= '0;
      use_unexp <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            {sync, hnd, len, anys, src, anyt, tag, comm, cmd} <= s_axis_tdata[96:0];
            idx <= '0;
            use_unexp <= (s_axis_tdata[1:0] == CMD_POST);
            if (!enable) begin
              result <= pack_out(ST_FORWARD, '0, '0, '0, '0, '0, 1'b0, 1'b0);
              state <= S_OUT;
            end else if (s_axis_tdata[1:0] == CMD_NONE) begin
              result <= pack_out(ST_NOT_FOUND, '0, '0, '0, '0, '0, 1'b0, 1'b0);
              state <= S_OUT;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          if (idx >= limit) begin
            state <= S_WRITE;
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (cmd == CMD_NONE) begin
            // move mode: copy the entry just read down one slot
            if (use_unexp) unexp_mem[idx[UW-1:0] - 1'b1] <= u_rd;
            else posted_mem[idx[PW-1:0] - 1'b1] <= p_rd;
            idx <= idx + 1'b1;
            state <= S_SHIFT;
          end else if (hit) begin
            if (cmd == CMD_SEND)
              result <= pack_out(ST_MATCHED, p_rd.handle, hnd, src, tag,
                                 trunc ? other_len : len, trunc, sync);
            else if (cmd == CMD_POST)
              result <= pack_out(ST_MATCHED, hnd, u_rd.handle, u_rd.src, u_rd.tag,
                                 trunc ? len : other_len, trunc, u_rd.sync);
            else
              result <= pack_out(ST_CANCELLED, hnd, '0, '0, '0, '0, 1'b0, 1'b0);
            idx <= idx + 1'b1;
            state <= S_SHIFT;
          end else begin
            idx <= idx + 1'b1;
            state <= S_READ;
          end
        end
        S_SHIFT: begin
          // entry idx is read this cycle and written one slot down in S_CHECK
          if (idx >= limit) begin
            if (use_unexp) unexp_count <= unexp_count - 1'b1;
            else posted_count <= posted_count - 1'b1;
            state <= S_OUT;
          end else begin
            state <= S_CHECK;
            cmd <= CMD_NONE;
          end
        end
        S_WRITE: begin
          state <= S_OUT;
          if (cmd == CMD_SEND) begin
            if (unexp_count >= (UW+1)'(UNEXPECTED_DEPTH)) begin
              result <= pack_out(ST_FULL, '0, '0, '0, '0, '0, 1'b0, 1'b0);
            end else begin
              unexp_mem[unexp_count[UW-1:0]] <= '{comm, tag, src, sync, hnd, len};
              unexp_count <= unexp_count + 1'b1;
              result <= pack_out(ST_UNEXPECTED, '0, '0, '0, '0, '0, 1'b0, 1'b0);
            end
          end else if (cmd == CMD_POST) begin
            if (anys && mpw) begin
              result <= pack_out(ST_FORWARD, '0, '0, '0, '0, '0, 1'b0, 1'b0);
            end else if (posted_count >= (PW+1)'(POSTED_DEPTH)) begin
              result <= pack_out(ST_FULL, '0, '0, '0, '0, '0, 1'b0, 1'b0);
            end else begin
              posted_mem[posted_count[PW-1:0]] <=
                '{comm, tag, anyt, src, anys, hnd, len};
              posted_count <= posted_count + 1'b1;
              result <= pack_out(ST_POSTED, '0, '0, '0, '0, '0, 1'b0, 1'b0);
            end
          end else begin
            result <= pack_out(ST_NOT_FOUND, '0, '0, '0, '0, '0, 1'b0, 1'b0);
          end
        end
        S_OUT: begin
          if (m_axis_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/mtme_checker.sv
`include "assert_macros.svh"
module mtme_props (
  input logic clk,
  input logic rst,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready
);
  `CHK_IMPLY(no_both, clk, rst, m_axis_tvalid, !s_axis_tready)
  `CHK_NEXT(busy_after_in, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `CHK_NEXT(hold_out, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
endmodule

bind message_tag_matching_engine mtme_props u_chk (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready));

// File: tb/mtme_checker.sv
`timescale 1ns / 1ps
module mtme_checker
  import mtme_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [InWidth-1:0]  s_axis_tdata,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutWidth-1:0] m_axis_tdata,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic                cfg_data,
  output int                  pending,
  output int                  errors
);

  localparam int PostDepth  = 32;
  localparam int UnexpDepth = 32;

  typedef struct packed {
    status_t     status;
    logic [15:0] recv_handle;
    logic [15:0] msg_handle;
    logic [11:0] src;
    logic [15:0] tag;
    logic [31:0] dlen;
    logic        trunc;
    logic        release_ok;
  } outcome_t;

  logic     en_q;
  logic     mpw_q;
  posted_t  posted_q[$];
  unexp_t   unexp_q[$];
  outcome_t outcomes_due[$];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic outcome_t match_engine(input logic [InWidth-1:0] d);
    cmd_t        cmd;
    logic [15:0] comm, tag, hnd;
    logic        anyt, anys, sync;
    logic [11:0] src;
    logic [31:0] len;
    outcome_t    o;
    posted_t     p;
    unexp_t      u;
    cmd  = cmd_t'(d[1:0]);
    comm = d[17:2];
    tag  = d[33:18];
    anyt = d[34];
    src  = d[46:35];
    anys = d[47];
    len  = d[79:48];
    hnd  = d[95:80];
    sync = d[96];
    o = '0;
    o.status = ST_NOT_FOUND;
    if (!en_q) begin
      o.status = ST_FORWARD;
      return o;
    end
    case (cmd)
      CMD_SEND: begin
        foreach (posted_q[i]) begin
          p = posted_q[i];
          if (p.comm == comm && (p.any_tag || p.tag == tag) && (p.any_src || p.src == src)) begin
            posted_q.delete(i);
            o.status = ST_MATCHED;
            o.recv_handle = p.handle;
            o.msg_handle = hnd;
            o.src = src;
            o.tag = tag;
            o.trunc = len > p.cap;
            o.dlen = o.trunc ? p.cap : len;
            o.release_ok = sync;
            return o;
          end
        end
        if (unexp_q.size() >= UnexpDepth) begin
          o.status = ST_FULL;
        end else begin
          u = '{comm: comm, tag: tag, src: src, sync: sync, handle: hnd, len: len};
          unexp_q.push_back(u);
          o.status = ST_UNEXPECTED;
        end
      end
      CMD_POST: begin
        foreach (unexp_q[i]) begin
          u = unexp_q[i];
          if (u.comm == comm && (anyt || u.tag == tag) && (anys || u.src == src)) begin
            unexp_q.delete(i);
            o.status = ST_MATCHED;
            o.recv_handle = hnd;
            o.msg_handle = u.handle;
            o.src = u.src;
            o.tag = u.tag;
            o.trunc = u.len > len;
            o.dlen = o.trunc ? len : u.len;
            o.release_ok = u.sync;
            return o;
          end
        end
        if (anys && mpw_q) begin
          o.status = ST_FORWARD;
        end else if (posted_q.size() >= PostDepth) begin
          o.status = ST_FULL;
        end else begin
          p = '{comm: comm, tag: tag, any_tag: anyt, src: src, any_src: anys,
                handle: hnd, cap: len};
          posted_q.push_back(p);
          o.status = ST_POSTED;
        end
      end
      CMD_CANCEL: begin
        foreach (posted_q[i]) begin
          if (posted_q[i].handle == hnd) begin
            posted_q.delete(i);
            o.status = ST_CANCELLED;
            o.recv_handle = hnd;
            return o;
          end
        end
      end
      default: o.status = ST_NOT_FOUND;
    endcase
    return o;
  endfunction

  always @(posedge clk) begin
    outcome_t g, w;
    if (rst) begin
      en_q = 1'b0;
      mpw_q = 1'b0;
      posted_q.delete();
      unexp_q.delete();
      outcomes_due.delete();
      errors = 0;
      pending = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_ENABLE) en_q = cfg_data;
        else mpw_q = cfg_data;
      end
      if (s_axis_tvalid && s_axis_tready) outcomes_due.push_back(match_engine(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        g = '{status: status_t'(m_axis_tdata[2:0]), recv_handle: m_axis_tdata[18:3],
              msg_handle: m_axis_tdata[34:19], src: m_axis_tdata[46:35],
              tag: m_axis_tdata[62:47], dlen: m_axis_tdata[94:63],
              trunc: m_axis_tdata[95], release_ok: m_axis_tdata[96]};
        if (outcomes_due.size() == 0) begin
          report("unexpected result beat", 32'(g.status), 32'd0);
        end else begin
          w = outcomes_due.pop_front();
          if (g.status != w.status)
            report("status", 32'(g.status), 32'(w.status));
          if (g.recv_handle != w.recv_handle)
            report("recv_handle", 32'(g.recv_handle), 32'(w.recv_handle));
          if (g.msg_handle != w.msg_handle)
            report("msg_handle", 32'(g.msg_handle), 32'(w.msg_handle));
          if (g.src != w.src)
            report("matched_source", 32'(g.src), 32'(w.src));
          if (g.tag != w.tag)
            report("matched_tag", 32'(g.tag), 32'(w.tag));
          if (g.dlen != w.dlen)
            report("delivered_length", g.dlen, w.dlen);
          if (g.trunc != w.trunc)
            report("truncated", 32'(g.trunc), 32'(w.trunc));
          if (g.release_ok != w.release_ok)
            report("sync_release", 32'(g.release_ok), 32'(w.release_ok));
          if (m_axis_tdata[OutWidth-1:97] != '0) report("padding", 32'd1, 32'd0);
        end
      end
      pending = outcomes_due.size();
    end
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import mtme_pkg::*;

  logic                clk;
  logic                rst;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // command, comm_id, tag, any_tag, source_rank, any_src, length, handle, is_sync
  logic [InWidth-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // status, recv_handle, msg_handle, matched_source, matched_tag,
  // delivered_length, truncated, sync_release
  logic [OutWidth-1:0] m_axis_tdata;
  logic                cfg_we;
  logic                cfg_index;
  logic                cfg_data;
  int                  pending;
  int                  errors;
  int                  burst_left;
  bit                  long_hold;

  message_tag_matching_engine u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  mtme_checker u_checker (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .errors(errors)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int mode, hold;
    bit held;
    m_axis_tready = 1'b0;
    mode = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold && !held) begin
        held = 1'b1;
        m_axis_tready = 1'b0;
        for (hold = 0; hold < 400; hold++) @(negedge clk);
      end
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: m_axis_tready = 1'b1;
        1: m_axis_tready = $urandom_range(0, 3) != 0;
        2: m_axis_tready = $urandom_range(0, 1) != 0;
        default: m_axis_tready = $urandom_range(0, 5) == 0;
      endcase
    end
  end

  function automatic logic [InWidth-1:0] beat(cmd_t cmd, logic [15:0] comm, logic [15:0] tag,
      logic anyt, logic [11:0] src, logic anys, logic [31:0] len, logic [15:0] hnd, logic sync);
    logic [InWidth-1:0] d;
    d = '0;
    d[96:0] = {sync, hnd, len, anys, src, anyt, tag, comm, cmd};
    return d;
  endfunction

  task automatic send_beat(input logic [InWidth-1:0] d);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = d;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_axis_tvalid = 1'b0;
      s_axis_tdata = InWidth'({$urandom, $urandom, $urandom, $urandom});
      repeat ($urandom_range(0, 8)) @(negedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic write_reg(input logic idx, input logic val);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // mostly a small key space so sends and receives meet
  function automatic logic [InWidth-1:0] random_beat();
    logic [15:0] comm, tag, hnd;
    logic [11:0] src;
    logic [31:0] len;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 10) return InWidth'({$urandom, $urandom, $urandom, $urandom});
    comm = (r < 15) ? 16'($urandom) : 16'($urandom_range(0, 2));
    tag  = (r < 20) ? 16'($urandom) : 16'($urandom_range(0, 3)) - 16'd1;
    src  = (r < 25) ? 12'($urandom) : 12'($urandom_range(0, 3));
    len  = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 64));
    hnd  = (r < 30) ? 16'($urandom) : 16'($urandom_range(0, 15));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return beat(CMD_SEND, comm, tag, 1'($urandom), src, 1'($urandom), len, hnd,
                              1'($urandom));
      4, 5, 6, 7: return beat(CMD_POST, comm, tag, $urandom_range(0, 4) == 0, src,
                              $urandom_range(0, 4) == 0, len, hnd, 1'($urandom));
      8: return beat(CMD_CANCEL, comm, tag, 1'($urandom), src, 1'($urandom), len, hnd,
                     1'($urandom));
      default: return beat(CMD_NONE, comm, tag, 1'($urandom), src, 1'($urandom), len, hnd,
                           1'($urandom));
    endcase
  endfunction

  initial begin
    int ph;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = REG_ENABLE;
    cfg_data = 1'b0;
    burst_left = 0;
    long_hold = 1'b0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // disabled: everything forwarded
    send_beat(beat(CMD_SEND, 16'hFFFF, 16'h8000, 1'b1, 12'hFFF, 1'b1, 32'hFFFFFFFF, 16'hFFFF,
                   1'b1));
    send_beat(beat(CMD_POST, 16'd0, 16'd0, 1'b0, 12'd0, 1'b0, 32'd0, 16'd0, 1'b0));
    write_reg(REG_ENABLE, 1'b1);
    write_reg(REG_MPW, 1'b0);
    // send then matching post, with truncation and sync release
    send_beat(beat(CMD_SEND, 16'hFFFF, 16'h7FFF, 1'b1, 12'hFFF, 1'b1, 32'hFFFFFFFF, 16'hAAAA,
                   1'b1));
    send_beat(beat(CMD_POST, 16'hFFFF, 16'h7FFF, 1'b0, 12'hFFF, 1'b0, 32'd100, 16'h5555, 1'b1));
    // post then send, wildcard tag and source, negative tag
    send_beat(beat(CMD_POST, 16'd7, 16'd0, 1'b1, 12'd0, 1'b1, 32'hFFFFFFFF, 16'd1, 1'b0));
    send_beat(beat(CMD_SEND, 16'd7, 16'h8000, 1'b0, 12'd9, 1'b0, 32'd0, 16'd2, 1'b0));
    // comm mismatch stays queued, then cancel by handle
    send_beat(beat(CMD_POST, 16'd1, 16'd3, 1'b0, 12'd4, 1'b0, 32'd8, 16'd9, 1'b0));
    send_beat(beat(CMD_SEND, 16'd2, 16'd3, 1'b0, 12'd4, 1'b0, 32'd8, 16'd10, 1'b0));
    send_beat(beat(CMD_POST, 16'd1, 16'd3, 1'b0, 12'd4, 1'b0, 32'd8, 16'd9, 1'b0));
    send_beat(beat(CMD_CANCEL, 16'd0, 16'd0, 1'b0, 12'd0, 1'b0, 32'd0, 16'd9, 1'b0));
    send_beat(beat(CMD_CANCEL, 16'd0, 16'd0, 1'b0, 12'd0, 1'b0, 32'd0, 16'd9, 1'b0));
    send_beat(beat(CMD_CANCEL, 16'd0, 16'd0, 1'b0, 12'd0, 1'b0, 32'd0, 16'd9, 1'b0));
    send_beat(beat(CMD_NONE, 16'd0, 16'd0, 1'b0, 12'd0, 1'b0, 32'd0, 16'd0, 1'b0));
    // equal lengths, wildcard source with mpw
    send_beat(beat(CMD_POST, 16'd2, 16'd3, 1'b0, 12'd0, 1'b1, 32'd8, 16'd11, 1'b1));
    write_reg(REG_MPW, 1'b1);
    send_beat(beat(CMD_POST, 16'd5, 16'd3, 1'b0, 12'd0, 1'b1, 32'd8, 16'd12, 1'b0));
    send_beat(beat(CMD_POST, 16'd5, 16'd3, 1'b1, 12'd6, 1'b0, 32'd8, 16'd13, 1'b0));

    for (ph = 0; ph < 6; ph++) begin
      write_reg(REG_ENABLE, ph != 5);
      write_reg(REG_MPW, ph[0]);
      if (ph == 1) long_hold = 1'b1;
      // fill the unexpected queue past its depth, then drain it
      if (ph == 2) begin
        for (int i = 0; i < 36; i++)
          send_beat(beat(CMD_SEND, 16'hBEEF, 16'(i), 1'b0, 12'd1, 1'b0, $urandom, 16'(i),
                         1'($urandom)));
        for (int i = 0; i < 36; i++)
          send_beat(beat(CMD_POST, 16'hBEEF, 16'(i), 1'b0, 12'd1, 1'b0, $urandom, 16'(i), 1'b0));
      end
      if (ph == 3) begin
        for (int i = 0; i < 36; i++)
          send_beat(beat(CMD_POST, 16'hCAFE, 16'(i), 1'b0, 12'd1, 1'b0, $urandom, 16'(i), 1'b0));
        for (int i = 0; i < 36; i++)
          send_beat(beat(CMD_SEND, 16'hCAFE, 16'(i), 1'b0, 12'd1, 1'b0, $urandom, 16'(i), 1'b1));
      end
      repeat (ph == 5 ? 60 : 200) send_beat(random_beat());
    end

    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
